// File: src/mre_pkg.sv
// shared types and constants for the mips r-type execute block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mre_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned IDX_W  = 5;
    localparam int unsigned REG_N  = 32;
    localparam int unsigned CMD_W  = 2;

    localparam logic [DATA_W-1:0] PC_STEP = 32'd4;

    typedef enum logic [CMD_W-1:0] {
        CMD_EXEC   = 2'd0,
        CMD_LOAD   = 2'd1,
        CMD_SET_PC = 2'd2
    } cmd_t;

    localparam logic [5:0] FN_SLL  = 6'h00;
    localparam logic [5:0] FN_SRL  = 6'h02;
    localparam logic [5:0] FN_JR   = 6'h08;
    localparam logic [5:0] FN_ADD  = 6'h20;
    localparam logic [5:0] FN_ADDU = 6'h21;
    localparam logic [5:0] FN_SUB  = 6'h22;
    localparam logic [5:0] FN_SUBU = 6'h23;
    localparam logic [5:0] FN_AND  = 6'h24;
    localparam logic [5:0] FN_SLT  = 6'h2a;
    localparam logic [5:0] FN_SLTU = 6'h2b;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [DATA_W-1:0] instruction;
        logic [IDX_W-1:0]  reg_index;
        logic [DATA_W-1:0] load_value;
    } req_t;

    typedef struct packed {
        logic [DATA_W-1:0] pc_out;
        logic [IDX_W-1:0]  dest_index;
        logic [DATA_W-1:0] dest_value;
        logic              dest_written;
        logic              overflow;
        logic              unknown_funct;
    } rsp_t;

    // register file write port
    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] data;
    } wr_req_t;

endpackage

`default_nettype wire

// File: src/mre_regfile.sv
// 32 x 32 register file: synchronous memory, one write and two read ports
// uses mre_pkg
`timescale 1ns / 1ps
`default_nettype none

module mre_regfile (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       rd_en,
    input  wire logic [mre_pkg::IDX_W-1:0]  rd_a_idx,
    input  wire logic [mre_pkg::IDX_W-1:0]  rd_b_idx,
    output logic      [mre_pkg::DATA_W-1:0] rd_a_data,
    output logic      [mre_pkg::DATA_W-1:0] rd_b_data,
    input  wire mre_pkg::wr_req_t           wr
);

    logic [mre_pkg::DATA_W-1:0] mem [mre_pkg::REG_N];
    logic [mre_pkg::REG_N-1:0]  valid_reg;
    logic [mre_pkg::DATA_W-1:0] rd_a_reg;
    logic [mre_pkg::DATA_W-1:0] rd_b_reg;
    logic                       rd_a_ok_reg;
    logic                       rd_b_ok_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.idx] <= wr.data;
        end
        if (rd_en)
        begin
            rd_a_reg <= mem[rd_a_idx];
            rd_b_reg <= mem[rd_b_idx];
        end
    end

    // valid bits stand in for the reset contents; entry zero is never written
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            rd_a_ok_reg <= 1'b0;
            rd_b_ok_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.idx] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_a_ok_reg <= valid_reg[rd_a_idx];
                rd_b_ok_reg <= valid_reg[rd_b_idx];
            end
        end
    end

    assign rd_a_data = rd_a_ok_reg ? rd_a_reg : '0;
    assign rd_b_data = rd_b_ok_reg ? rd_b_reg : '0;

endmodule

`default_nettype wire

// File: src/mre_alu.sv
// execute logic: decodes one request, computes result, write-back and next pc
// uses mre_pkg
`timescale 1ns / 1ps
`default_nettype none

module mre_alu (
    input  wire mre_pkg::req_t              req,
    input  wire logic [mre_pkg::DATA_W-1:0] opa,
    input  wire logic [mre_pkg::DATA_W-1:0] opb,
    input  wire logic [mre_pkg::DATA_W-1:0] pc,
    output mre_pkg::rsp_t                   rsp,
    output mre_pkg::wr_req_t                wr,
    output logic      [mre_pkg::DATA_W-1:0] pc_next
);

    logic [5:0]                  funct;
    logic [4:0]                  shamt;
    logic [mre_pkg::IDX_W-1:0]   rd;
    logic [mre_pkg::DATA_W-1:0]  sum;
    logic [mre_pkg::DATA_W-1:0]  diff;
    logic [mre_pkg::DATA_W-1:0]  res;
    logic                        has_res;
    logic                        ovf;
    logic                        unk;

    assign funct = req.instruction[5:0];
    assign shamt = req.instruction[10:6];
    assign rd    = req.instruction[15:11];
    assign sum   = opa + opb;
    assign diff  = opa - opb;

    always_comb
    begin
        res     = '0;
        has_res = 1'b1;
        ovf     = 1'b0;
        unk     = 1'b0;
        pc_next = pc + mre_pkg::PC_STEP;
        case (funct)
            mre_pkg::FN_ADD:
            begin
                res = sum;
                ovf = (opa[31] ^ sum[31]) & (opb[31] ^ sum[31]);
            end
            mre_pkg::FN_ADDU: res = sum;
            mre_pkg::FN_AND:  res = opa & opb;
            mre_pkg::FN_JR:
            begin
                has_res = 1'b0;
                pc_next = opa;
            end
            mre_pkg::FN_SLT:
                res = {31'd0, ($signed(opa) < $signed(opb))};
            mre_pkg::FN_SLTU: res = {31'd0, (opa < opb)};
            mre_pkg::FN_SLL:  res = opb << shamt;
            mre_pkg::FN_SRL:  res = opb >> shamt;
            mre_pkg::FN_SUB,
            mre_pkg::FN_SUBU: res = diff;
            default:
            begin
                has_res = 1'b0;
                unk     = 1'b1;
            end
        endcase

        rsp = '0;
        wr  = '0;
        case (mre_pkg::cmd_t'(req.command))
            mre_pkg::CMD_EXEC:
            begin
                rsp.dest_index    = rd;
                rsp.dest_value    = has_res ? res : '0;
                rsp.overflow      = ovf;
                rsp.unknown_funct = unk;
                wr.en             = has_res && (rd != '0);
                wr.idx            = rd;
                wr.data           = res;
            end
            mre_pkg::CMD_LOAD:
            begin
                pc_next        = pc;
                rsp.dest_index = req.reg_index;
                rsp.dest_value = req.load_value;
                wr.en          = (req.reg_index != '0);
                wr.idx         = req.reg_index;
                wr.data        = req.load_value;
            end
            mre_pkg::CMD_SET_PC:
            begin
                pc_next = req.load_value;
            end
            default:
            begin
                pc_next = pc;
            end
        endcase
        rsp.dest_written = wr.en;
        rsp.pc_out       = pc_next;
    end

endmodule

`default_nettype wire

// File: src/mips_rtype_execute.sv
// top level of the mips r-type execute block: pipeline control, pc, forwarding
// uses mre_pkg, mre_regfile, mre_alu
`timescale 1ns / 1ps
`default_nettype none

// Executes one request per clock while responses are taken: an R-format
// instruction, a direct register load, or a program counter set, and returns
// one response per request in order. Two stages: the accept edge issues both
// register reads (rs, rt) to the synchronous register file; the edge at which
// the execute stage fires executes, writes back and loads the response
// register. A new request may be accepted every cycle while the response
// register is free or draining. The write made by the request just ahead is
// forwarded to the reads of the following one, since its memory read can
// happen on the same edge as that write. The register file resets to zero
// through per-entry valid bits, so there is no clearing pass and the block
// takes requests right after reset. While a response waits, one more request
// can enter the execute stage; after that cmd_ready stays low until the
// response is taken. cmd_ready follows rsp_ready in the same cycle when the
// execute stage is occupied and a response is waiting.

module mips_rtype_execute (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cmd_valid,
    output logic                cmd_ready,
    input  wire mre_pkg::req_t  cmd_data,
    output logic                rsp_valid,
    input  wire logic           rsp_ready,
    output mre_pkg::rsp_t       rsp_data
);

    logic                          s1_valid_reg;
    mre_pkg::req_t                 s1_req_reg;
    logic [mre_pkg::DATA_W-1:0]    pc_reg;
    mre_pkg::wr_req_t              fwd_reg;
    logic                          rsp_valid_reg;
    mre_pkg::rsp_t                 rsp_data_reg;

    logic                          accept;
    logic                          s1_fire;
    logic [mre_pkg::DATA_W-1:0]    rd_a_data;
    logic [mre_pkg::DATA_W-1:0]    rd_b_data;
    logic [mre_pkg::DATA_W-1:0]    opa;
    logic [mre_pkg::DATA_W-1:0]    opb;
    logic [mre_pkg::IDX_W-1:0]     rs_idx;
    logic [mre_pkg::IDX_W-1:0]     rt_idx;
    mre_pkg::rsp_t                 alu_rsp;
    mre_pkg::wr_req_t              alu_wr;
    mre_pkg::wr_req_t              wr;
    logic [mre_pkg::DATA_W-1:0]    pc_next;

    // execute stage moves on whenever the response register is free or draining
    assign s1_fire   = s1_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign cmd_ready = !s1_valid_reg || s1_fire;
    assign accept    = cmd_valid && cmd_ready;

    mre_regfile u_regfile (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (accept),
        .rd_a_idx  (cmd_data.instruction[25:21]),
        .rd_b_idx  (cmd_data.instruction[20:16]),
        .rd_a_data (rd_a_data),
        .rd_b_data (rd_b_data),
        .wr        (wr)
    );

    // operand forwarding from the most recent write-back
    assign rs_idx = s1_req_reg.instruction[25:21];
    assign rt_idx = s1_req_reg.instruction[20:16];
    assign opa = (fwd_reg.en && fwd_reg.idx == rs_idx) ? fwd_reg.data : rd_a_data;
    assign opb = (fwd_reg.en && fwd_reg.idx == rt_idx) ? fwd_reg.data : rd_b_data;

    mre_alu u_alu (
        .req     (s1_req_reg),
        .opa     (opa),
        .opb     (opb),
        .pc      (pc_reg),
        .rsp     (alu_rsp),
        .wr      (alu_wr),
        .pc_next (pc_next)
    );

    // write only when the execute stage actually retires
    always_comb
    begin
        wr    = alu_wr;
        wr.en = alu_wr.en && s1_fire;
    end

    // request payload held in the execute stage, and the response payload on retire
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_req_reg <= cmd_data;
        end
        if (s1_fire)
        begin
            rsp_data_reg <= alu_rsp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            pc_reg        <= '0;
            fwd_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end

            // forward record holds the last retired write until the next retire
            if (s1_fire)
            begin
                pc_reg  <= pc_next;
                fwd_reg <= alu_wr;
            end

            if (s1_fire)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

endmodule

`default_nettype wire
